/* rtl/u2c_pkg.sv */
// Shared types and constants for the UTF-8 to code point decoder.
package u2c_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned ContW  = 6;

  localparam logic [ByteW-1:0] LeadBit = 8'h80;
  localparam logic [ByteW-1:0] AsciiMask = 8'h7F;
  localparam logic [ByteW-1:0] ContMask = 8'h3F;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_string;
  } in_req_t;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             final_char;
  } out_req_t;

endpackage

/* rtl/utf8_to_codepoint_decoder.sv */
// Top level of the UTF-8 to code point decoder.
//
//   Channel  Direction  Handshake             Payload
//   in       consumer   in_valid_i/in_stall_o  in_data_i  (byte, end of string)
//   out      producer   out_valid_o/out_stall_i out_data_o (code point, final flag)
//
// A byte is taken every cycle unless in_stall_o is high; it passes the input register,
// the combinational decode and the result register; that decode sets the rate.
// Reset clears the sequence state and all valid flags; payload registers are not reset.
// A stalled output fills the skid entry, after which the input stalls until it drains.
module utf8_to_codepoint_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  u2c_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output u2c_pkg::out_req_t out_data_o
);

  logic              in_valid_q, in_valid_d;
  u2c_pkg::in_req_t  in_q;
  logic              buf_full;
  logic              adv;
  logic              res_valid;
  u2c_pkg::out_req_t res;
  logic              in_accept;

  assign adv        = in_valid_q && !buf_full;
  assign in_stall_o = in_valid_q && buf_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  u2c_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .req_i       (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  u2c_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/u2c_step.sv */
// Decode step: sequence state plus the per-byte lead/continuation logic.
module u2c_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  u2c_pkg::in_req_t  req_i,
  output logic              res_valid_o,
  output u2c_pkg::out_req_t res_o
);

  logic [u2c_pkg::CodeW-1:0]  char_accum_q, char_accum_d;
  logic [u2c_pkg::CountW-1:0] bytes_remaining_q, bytes_remaining_d;
  logic [u2c_pkg::CodeW-1:0]  accum_new;
  logic [u2c_pkg::CountW-1:0] rem_new;
  logic [u2c_pkg::CountW-1:0] ones;
  logic [u2c_pkg::ByteW-1:0]  lead_mask;
  logic                       run;
  logic                       emit;

  // Count the run of ones below bit 7 of a lead byte.
  always_comb begin
    ones = '0;
    run  = 1'b1;
    for (int i = u2c_pkg::ByteW - 2; i >= 0; i--) begin
      run = run & req_i.in_byte[i];
      ones = ones + {{(u2c_pkg::CountW-1){1'b0}}, run};
    end
  end

  // An ASCII byte keeps seven bits; otherwise the lead mask keeps 6 - n bits; six or seven ones leave no payload bits.
  always_comb begin
    if ((req_i.in_byte & u2c_pkg::LeadBit) == '0) begin
      lead_mask = u2c_pkg::AsciiMask;
    end else if (ones >= 3'd6) begin
      lead_mask = '0;
    end else begin
      lead_mask = u2c_pkg::ContMask >> ones;
    end
  end

  always_comb begin
    if (bytes_remaining_q == '0) begin
      accum_new = {{(u2c_pkg::CodeW-u2c_pkg::ByteW){1'b0}}, req_i.in_byte & lead_mask};
      rem_new   = ((req_i.in_byte & u2c_pkg::LeadBit) == '0) ? '0 : ones;
    end else begin
      accum_new = {char_accum_q[u2c_pkg::CodeW-u2c_pkg::ContW-1:0],
                   req_i.in_byte[u2c_pkg::ContW-1:0]};
      rem_new   = bytes_remaining_q - 3'd1;
    end
    emit = (rem_new == '0) || req_i.end_of_string;

    res_valid_o      = adv_i && emit;
    res_o.code_point = accum_new;
    res_o.final_char = req_i.end_of_string;

    char_accum_d      = char_accum_q;
    bytes_remaining_d = bytes_remaining_q;
    if (adv_i) begin
      char_accum_d      = emit ? '0 : accum_new;
      bytes_remaining_d = emit ? '0 : rem_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_accum_q      <= '0;
      bytes_remaining_q <= '0;
    end else begin
      char_accum_q      <= char_accum_d;
      bytes_remaining_q <= bytes_remaining_d;
    end
  end

endmodule

/* rtl/u2c_out_buf.sv */
// Result register plus a skid entry that holds one result for a stalled consumer.
module u2c_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u2c_pkg::out_req_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output u2c_pkg::out_req_t out_data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  u2c_pkg::out_req_t out_q, out_d;
  u2c_pkg::out_req_t skid_q, skid_d;
  logic              pop;

  assign pop = out_valid_q && !out_stall_i;

  // A push only arrives while the skid entry is empty.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/u2c_checker.sv */
// Port-level assertions for the decoder, bound to the top level.
module u2c_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input u2c_pkg::in_req_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input u2c_pkg::out_req_t out_data_o
);

  // A stalled result request holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A stalled input request is held by the sender.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input request changed");

  // The input only backs up once a result is waiting.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // With the output still stalled, nothing can drain, so the input stall persists.
  a_stall_persists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_stall_i |=> in_stall_o)
    else $error("input stall released while output stalled");

  // Leaving reset, the block is empty.
  a_reset_empty: assert property (@(posedge clk_i)
    !$past(rst_ni) && rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("block not empty after reset");

endmodule

bind utf8_to_codepoint_decoder u2c_checker u_u2c_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
